FILE: rtl/pvs_pkg.sv
// Shared constants, register codes and helper functions for the pixel vignette shader.
// No dependencies; imported by pvs_pow, pixel_vignette_shader and its testbench.
`timescale 1ns / 1ps
package pvs_pkg;

    localparam int COORD_BITS   = 12;
    localparam int CHANNEL_BITS = 8;
    localparam int SIZE_BITS    = 13;
    localparam int GAIN_BITS    = 16;
    localparam int EXP_BITS     = 16;
    localparam int CFG_BITS     = 16;
    localparam int Q_BITS       = 16;
    localparam int BASE_BITS    = 20;
    localparam int K_BITS       = 5;
    localparam int FACTOR_BITS  = 17;

    localparam int DIV_STAGES = 8;
    localparam int PRE_LAT    = DIV_STAGES + 4;
    localparam int POW_LAT    = 37;
    localparam int PIPE_LAT   = PRE_LAT + POW_LAT;

    typedef enum logic [1:0] {
        REG_WIDTH,
        REG_HEIGHT,
        REG_GAIN,
        REG_EXPONENT
    } t_cfg_reg;

    // one restoring step: returns {quotient bit, new remainder}
    function automatic logic [SIZE_BITS:0] pvs_div_step(input logic [SIZE_BITS-1:0] rem,
                                                        input logic [SIZE_BITS-1:0] den);
        logic [SIZE_BITS:0] dbl;
        logic [SIZE_BITS:0] dif;
        dbl = {rem, 1'b0};
        dif = dbl - {1'b0, den};
        if (dbl >= {1'b0, den}) begin
            return {1'b1, dif[SIZE_BITS-1:0]};
        end
        return {1'b0, dbl[SIZE_BITS-1:0]};
    endfunction

    // 2^(-2^-k) in Q0.32, by repeated integer square roots (elaboration only)
    function automatic logic [31:0] pvs_exp_const(input int k);
        logic [63:0] c;
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        c = 64'd1 << 31;
        for (int i = 1; i <= k; i++) begin
            v = c << 32;
            r = '0;
            b = 64'h4000_0000_0000_0000;
            for (int j = 0; j < 32; j++) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            c = r;
        end
        return c[31:0];
    endfunction

endpackage

FILE: rtl/pvs_pow.sv
// Pipelined power unit: base^exponent through log2 squaring rounds and exp2 products.
// Depends on pvs_pkg.
`timescale 1ns / 1ps
module pvs_pow (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [pvs_pkg::BASE_BITS-1:0]      i_base,
    input  logic [pvs_pkg::EXP_BITS-1:0]       i_exponent,
    output logic [pvs_pkg::FACTOR_BITS-1:0]    o_factor
);
    import pvs_pkg::*;

    // leading-one stage
    logic [BASE_BITS-1:0] r_b0;
    logic [K_BITS-1:0]    r_k0;
    logic                 r_z0;
    logic                 r_e0;
    logic [K_BITS-1:0]    w_k;

    always_comb begin
        w_k = '0;
        for (int i = 0; i < BASE_BITS; i++) begin
            if (i_base[i]) w_k = K_BITS'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b0 <= i_base;
            r_k0 <= w_k;
            r_z0 <= (i_base == '0);
            r_e0 <= (i_exponent == '0);
        end
    end

    // normalise and square rounds
    logic [Q_BITS:0]   r_lm [0:16];
    logic [Q_BITS-1:0] r_lf [0:16];
    logic [K_BITS-1:0] r_lk [0:16];
    logic              r_lz [0:16];
    logic              r_le [0:16];
    logic [BASE_BITS+Q_BITS-1:0] w_norm;

    assign w_norm = {r_b0, {Q_BITS{1'b0}}} >> r_k0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lm[0] <= w_norm[Q_BITS:0];
            r_lf[0] <= '0;
            r_lk[0] <= r_k0;
            r_lz[0] <= r_z0;
            r_le[0] <= r_e0;
        end
    end

    for (genvar g = 0; g < 16; g++) begin : g_log
        logic [2*Q_BITS+1:0] w_sq;
        logic [Q_BITS+1:0]   w_t;
        assign w_sq = r_lm[g] * r_lm[g];
        assign w_t  = w_sq[2*Q_BITS+1:Q_BITS];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_lm[g+1] <= w_t[Q_BITS+1] ? w_t[Q_BITS+1:1] : w_t[Q_BITS:0];
                r_lf[g+1] <= {r_lf[g][Q_BITS-2:0], w_t[Q_BITS+1]};
                r_lk[g+1] <= r_lk[g];
                r_lz[g+1] <= r_lz[g];
                r_le[g+1] <= r_le[g];
            end
        end
    end

    // scale log by exponent, floor to Q.16
    logic signed [21:0] w_l;
    logic signed [5:0]  w_km;
    logic signed [38:0] w_prod;
    logic signed [26:0] r_y;
    logic               r_ye;
    logic               r_yz;

    assign w_km   = $signed({1'b0, r_lk[16]}) - 6'sd16;
    assign w_l    = {w_km, r_lf[16]};
    assign w_prod = w_l * $signed({1'b0, i_exponent});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y  <= w_prod[38:12];
            r_ye <= r_le[16];
            r_yz <= r_lz[16];
        end
    end

    // split into integer shift and fraction bits
    logic [26:0]       w_n;
    logic [10:0]       w_ip;
    logic              w_neg;
    logic [31:0]       r_xacc  [0:16];
    logic              r_xaone [0:16];
    logic [Q_BITS-1:0] r_xf    [0:16];
    logic [4:0]        r_xip   [0:16];
    logic              r_xone  [0:16];
    logic              r_xzero [0:16];

    assign w_neg = r_y[26];
    assign w_n   = 27'(-r_y);
    assign w_ip  = w_n[26:16];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xacc[0]  <= '0;
            r_xaone[0] <= 1'b1;
            r_xf[0]    <= w_n[15:0];
            r_xip[0]   <= w_ip[4:0];
            r_xone[0]  <= r_ye || (!r_yz && !w_neg);
            r_xzero[0] <= !r_ye && (r_yz || (w_neg && (w_ip > 11'd16)));
        end
    end

    for (genvar g = 1; g <= 16; g++) begin : g_exp
        localparam logic [31:0] C_K = pvs_exp_const(g);
        logic [63:0] w_mul;
        assign w_mul = 64'(r_xacc[g-1]) * 64'(C_K);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_xf[g-1][16-g]) begin
                    r_xacc[g]  <= r_xaone[g-1] ? C_K : w_mul[63:32];
                    r_xaone[g] <= 1'b0;
                end else begin
                    r_xacc[g]  <= r_xacc[g-1];
                    r_xaone[g] <= r_xaone[g-1];
                end
                r_xf[g]    <= r_xf[g-1];
                r_xip[g]   <= r_xip[g-1];
                r_xone[g]  <= r_xone[g-1];
                r_xzero[g] <= r_xzero[g-1];
            end
        end
    end

    // final shift and special cases
    logic [FACTOR_BITS-1:0] w_val;
    logic [FACTOR_BITS-1:0] w_shr;
    logic [FACTOR_BITS-1:0] r_factor;

    assign w_val = r_xaone[16] ? FACTOR_BITS'(1 << Q_BITS) : {1'b0, r_xacc[16][31:16]};
    assign w_shr = w_val >> r_xip[16];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_xone[16]) begin
                r_factor <= FACTOR_BITS'(1 << Q_BITS);
            end else if (r_xzero[16]) begin
                r_factor <= '0;
            end else begin
                r_factor <= w_shr;
            end
        end
    end

    assign o_factor = r_factor;

endmodule

FILE: rtl/pixel_vignette_shader.sv
// Top level of the pixel vignette shader: coordinate division, vignette base, colour scaling.
// Depends on pvs_pkg and pvs_pow.
// Datapath: 49 pipe stages plus the output register from input beat to result beat.
// Throughput: one pixel per clock while the skid is free; 16-round log2, 16-step exp2 fully staged.
// Reset: synchronous active-low; clears valid bits, output/skid flags and loads register defaults.
`timescale 1ns / 1ps
module pixel_vignette_shader (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_index,
    input  logic [pvs_pkg::CFG_BITS-1:0]       i_cfg_data,
    input  logic                               i_pixel_valid,
    output logic                               o_pixel_ready,
    input  logic [pvs_pkg::COORD_BITS-1:0]     i_pixel_x,
    input  logic [pvs_pkg::COORD_BITS-1:0]     i_pixel_y,
    input  logic [pvs_pkg::CHANNEL_BITS-1:0]   i_red_in,
    input  logic [pvs_pkg::CHANNEL_BITS-1:0]   i_green_in,
    input  logic [pvs_pkg::CHANNEL_BITS-1:0]   i_blue_in,
    input  logic [pvs_pkg::CHANNEL_BITS-1:0]   i_alpha_in,
    output logic                               o_result_valid,
    input  logic                               i_result_ready,
    output logic [pvs_pkg::CHANNEL_BITS-1:0]   o_red_out,
    output logic [pvs_pkg::CHANNEL_BITS-1:0]   o_green_out,
    output logic [pvs_pkg::CHANNEL_BITS-1:0]   o_blue_out,
    output logic [pvs_pkg::CHANNEL_BITS-1:0]   o_alpha_out
);
    import pvs_pkg::*;

    localparam int SIDE_BITS = 4 * CHANNEL_BITS;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [SIZE_BITS-1:0] r_width;
    logic [SIZE_BITS-1:0] r_height;
    logic [GAIN_BITS-1:0] r_gain;
    logic [EXP_BITS-1:0]  r_exponent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= SIZE_BITS'(1024);
            r_height   <= SIZE_BITS'(768);
            r_gain     <= GAIN_BITS'(3840);
            r_exponent <= EXP_BITS'(1024);
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_WIDTH:    r_width    <= i_cfg_data[SIZE_BITS-1:0];
                REG_HEIGHT:   r_height   <= i_cfg_data[SIZE_BITS-1:0];
                REG_GAIN:     r_gain     <= i_cfg_data[GAIN_BITS-1:0];
                REG_EXPONENT: r_exponent <= i_cfg_data[EXP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // a zero frame size acts as one
    logic [SIZE_BITS-1:0] w_wd;
    logic [SIZE_BITS-1:0] w_hd;
    assign w_wd = (r_width  == '0) ? SIZE_BITS'(1) : r_width;
    assign w_hd = (r_height == '0) ? SIZE_BITS'(1) : r_height;

    // ---------------------------------------------------------------
    // Global advance: the whole pipe moves while the skid stage is free,
    // so the input keeps flowing while one finished beat waits at the output.
    // ---------------------------------------------------------------
    logic w_en;
    logic r_out_vld;
    logic r_skid_vld;

    assign w_en          = !r_skid_vld;
    assign o_pixel_ready = w_en;

    // valid bits and pass-through channels travel alongside the data
    logic                 r_vld  [0:PIPE_LAT-1];
    logic [SIDE_BITS-1:0] r_side [0:PIPE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < PIPE_LAT; s++) r_vld[s] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_pixel_valid;
            for (int s = 1; s < PIPE_LAT; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= {i_red_in, i_green_in, i_blue_in, i_alpha_in};
            for (int s = 1; s < PIPE_LAT; s++) r_side[s] <= r_side[s-1];
        end
    end

    // ---------------------------------------------------------------
    // Stage 0 and stages 1..8: u = x*2^16/W, v = y*2^16/H, two quotient
    // bits per stage. A coordinate at or past the frame size saturates.
    // ---------------------------------------------------------------
    logic [SIZE_BITS-1:0] r_xr   [0:DIV_STAGES];
    logic [SIZE_BITS-1:0] r_yr   [0:DIV_STAGES];
    logic [Q_BITS-1:0]    r_xq   [0:DIV_STAGES];
    logic [Q_BITS-1:0]    r_yq   [0:DIV_STAGES];
    logic                 r_xsat [0:DIV_STAGES];
    logic                 r_ysat [0:DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xr[0]   <= SIZE_BITS'(i_pixel_x);
            r_yr[0]   <= SIZE_BITS'(i_pixel_y);
            r_xq[0]   <= '0;
            r_yq[0]   <= '0;
            r_xsat[0] <= SIZE_BITS'(i_pixel_x) >= w_wd;
            r_ysat[0] <= SIZE_BITS'(i_pixel_y) >= w_hd;
        end
    end

    for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_div
        logic [SIZE_BITS:0] w_xa;
        logic [SIZE_BITS:0] w_xb;
        logic [SIZE_BITS:0] w_ya;
        logic [SIZE_BITS:0] w_yb;
        assign w_xa = pvs_div_step(r_xr[g-1], w_wd);
        assign w_xb = pvs_div_step(w_xa[SIZE_BITS-1:0], w_wd);
        assign w_ya = pvs_div_step(r_yr[g-1], w_hd);
        assign w_yb = pvs_div_step(w_ya[SIZE_BITS-1:0], w_hd);
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_xr[g]   <= w_xb[SIZE_BITS-1:0];
                r_yr[g]   <= w_yb[SIZE_BITS-1:0];
                r_xq[g]   <= {r_xq[g-1][Q_BITS-3:0], w_xa[SIZE_BITS], w_xb[SIZE_BITS]};
                r_yq[g]   <= {r_yq[g-1][Q_BITS-3:0], w_ya[SIZE_BITS], w_yb[SIZE_BITS]};
                r_xsat[g] <= r_xsat[g-1];
                r_ysat[g] <= r_ysat[g-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stages 9..11: pu = u(1-u), pv = v(1-v), p = pu*pv, base = p*gain
    // ---------------------------------------------------------------
    logic [Q_BITS-1:0]          w_u;
    logic [Q_BITS-1:0]          w_v;
    logic [2*Q_BITS:0]          w_pux;
    logic [2*Q_BITS:0]          w_pvx;
    logic [14:0]                r_pu;
    logic [14:0]                r_pv;
    logic [29:0]                w_px;
    logic [12:0]                r_p;
    logic [28:0]                w_bx;
    logic [BASE_BITS-1:0]       r_base;
    logic [FACTOR_BITS-1:0]     w_factor;

    assign w_u   = r_xsat[DIV_STAGES] ? '1 : r_xq[DIV_STAGES];
    assign w_v   = r_ysat[DIV_STAGES] ? '1 : r_yq[DIV_STAGES];
    assign w_pux = (2*Q_BITS+1)'(w_u) * ((2*Q_BITS+1)'(1 << Q_BITS) - (2*Q_BITS+1)'(w_u));
    assign w_pvx = (2*Q_BITS+1)'(w_v) * ((2*Q_BITS+1)'(1 << Q_BITS) - (2*Q_BITS+1)'(w_v));
    assign w_px  = r_pu * r_pv;
    assign w_bx  = r_p * r_gain;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pu   <= w_pux[30:16];
            r_pv   <= w_pvx[30:16];
            r_p    <= w_px[28:16];
            r_base <= w_bx[27:8];
        end
    end

    // stages 12..48: base raised to the exponent, clamped factor in Q1.16
    pvs_pow u_pow (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_base     (r_base),
        .i_exponent (r_exponent),
        .o_factor   (w_factor)
    );

    // ---------------------------------------------------------------
    // Colour scaling straight into the output or skid register
    // ---------------------------------------------------------------
    logic [SIDE_BITS-1:0]                w_last;
    logic [CHANNEL_BITS+FACTOR_BITS-1:0] w_rx;
    logic [CHANNEL_BITS+FACTOR_BITS-1:0] w_gx;
    logic [CHANNEL_BITS+FACTOR_BITS-1:0] w_bxc;
    logic [SIDE_BITS-1:0]                w_res;

    assign w_last = r_side[PIPE_LAT-1];
    assign w_rx   = w_last[4*CHANNEL_BITS-1:3*CHANNEL_BITS] * w_factor;
    assign w_gx   = w_last[3*CHANNEL_BITS-1:2*CHANNEL_BITS] * w_factor;
    assign w_bxc  = w_last[2*CHANNEL_BITS-1:CHANNEL_BITS]   * w_factor;
    assign w_res  = {w_rx[Q_BITS+CHANNEL_BITS-1:Q_BITS],
                     w_gx[Q_BITS+CHANNEL_BITS-1:Q_BITS],
                     w_bxc[Q_BITS+CHANNEL_BITS-1:Q_BITS],
                     w_last[CHANNEL_BITS-1:0]};

    logic [SIDE_BITS-1:0] r_out;
    logic [SIDE_BITS-1:0] r_skid;
    logic [SIDE_BITS-1:0] n_out;
    logic [SIDE_BITS-1:0] n_skid;
    logic                 n_out_vld;
    logic                 n_skid_vld;
    logic                 w_take;
    logic                 w_arrive;

    assign w_take   = r_out_vld && i_result_ready;
    assign w_arrive = w_en && r_vld[PIPE_LAT-1];

    always_comb begin
        n_out      = r_out;
        n_skid     = r_skid;
        n_out_vld  = r_out_vld;
        n_skid_vld = r_skid_vld;
        if (w_arrive) begin
            // land in the output register if it frees up, else park in the skid
            if (!r_out_vld || w_take) begin
                n_out     = w_res;
                n_out_vld = 1'b1;
            end else begin
                n_skid     = w_res;
                n_skid_vld = 1'b1;
            end
        end else if (w_take) begin
            if (r_skid_vld) begin
                n_out      = r_skid;
                n_skid_vld = 1'b0;
            end else begin
                n_out_vld = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_result_valid = r_out_vld;
    assign o_red_out      = r_out[4*CHANNEL_BITS-1:3*CHANNEL_BITS];
    assign o_green_out    = r_out[3*CHANNEL_BITS-1:2*CHANNEL_BITS];
    assign o_blue_out     = r_out[2*CHANNEL_BITS-1:CHANNEL_BITS];
    assign o_alpha_out    = r_out[CHANNEL_BITS-1:0];

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid holds a beat while the output register is empty");

    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> !o_pixel_ready)
        else $error("input accepted while the skid stage is occupied");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_result_ready) |=> r_out_vld)
        else $error("unaccepted result beat dropped");

endmodule

FILE: verif/pixel_vignette_shader_tb.sv
// Self-checking testbench for pixel_vignette_shader: a directed table, then random pixels
// under random register settings, each checked against a typed or a locally predicted result.
// Depends on pvs_pkg (register codes, widths) and the pixel_vignette_shader RTL.
`timescale 1ns / 1ps
module pixel_vignette_shader_tb;
    import pvs_pkg::*;

    typedef struct {
        logic [COORD_BITS-1:0]   x;
        logic [COORD_BITS-1:0]   y;
        logic [CHANNEL_BITS-1:0] r;
        logic [CHANNEL_BITS-1:0] g;
        logic [CHANNEL_BITS-1:0] b;
        logic [CHANNEL_BITS-1:0] a;
    } t_pixel;

    typedef struct {
        logic [CHANNEL_BITS-1:0] r;
        logic [CHANNEL_BITS-1:0] g;
        logic [CHANNEL_BITS-1:0] b;
        logic [CHANNEL_BITS-1:0] a;
    } t_shaded;

    // One row of the directed table: an optional register write made while the
    // block is idle, then one pixel; the shaded result is typed in where obvious.
    typedef struct {
        bit       do_write;
        t_cfg_reg reg_sel;
        int       reg_val;
        t_pixel   px;
        bit       typed;
        t_shaded  shade;
    } t_vec_row;

    localparam int PIPE_WAIT   = 60;
    localparam int CYCLE_LIMIT = 300000;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [1:0]              i_cfg_index;
    logic [CFG_BITS-1:0]     i_cfg_data;
    logic                    i_pixel_valid;
    logic                    o_pixel_ready;
    logic [COORD_BITS-1:0]   i_pixel_x;
    logic [COORD_BITS-1:0]   i_pixel_y;
    logic [CHANNEL_BITS-1:0] i_red_in;
    logic [CHANNEL_BITS-1:0] i_green_in;
    logic [CHANNEL_BITS-1:0] i_blue_in;
    logic [CHANNEL_BITS-1:0] i_alpha_in;
    logic                    o_result_valid;
    logic                    i_result_ready;
    logic [CHANNEL_BITS-1:0] o_red_out;
    logic [CHANNEL_BITS-1:0] o_green_out;
    logic [CHANNEL_BITS-1:0] o_blue_out;
    logic [CHANNEL_BITS-1:0] o_alpha_out;

    // local copy of the register file
    logic [SIZE_BITS-1:0] frame_w;
    logic [SIZE_BITS-1:0] frame_h;
    logic [GAIN_BITS-1:0] gain_q8;
    logic [EXP_BITS-1:0]  exponent_q12;

    logic [63:0] exp2_root [1:16];   // 2^(-2^-k) in Q0.32
    t_shaded     shade_queue [$];

    int tx_idle_pct;
    int rx_idle_pct;
    int cycles = 0;
    int mismatches = 0;
    int pixels_sent;
    int pixels_checked = 0;
    int reg_writes;

    pixel_vignette_shader u_top (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, shade_queue.size());
            $display("pixel_vignette_shader_tb: FAIL");
            $finish;
        end
    end

    // Receiver: stall the result channel at random.
    always @(negedge i_clk) begin
        i_result_ready = ($urandom_range(99) >= rx_idle_pct);
    end

    // Result checker: every result beat must match the oldest expectation.
    always @(posedge i_clk) begin
        t_shaded want;
        if (i_rst_n && o_result_valid && i_result_ready) begin
            if (shade_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result beat: r %0d g %0d b %0d a %0d",
                             o_red_out, o_green_out, o_blue_out, o_alpha_out);
                end
            end else begin
                want = shade_queue.pop_front();
                pixels_checked++;
                if (want.r !== o_red_out || want.g !== o_green_out ||
                    want.b !== o_blue_out || want.a !== o_alpha_out) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display({"mismatch: expected r %0d g %0d b %0d a %0d, ",
                                  "got r %0d g %0d b %0d a %0d"},
                                 want.r, want.g, want.b, want.a,
                                 o_red_out, o_green_out, o_blue_out, o_alpha_out);
                    end
                end
            end
        end
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] val);
        logic [63:0] root;
        logic [63:0] bitv;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > val) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (val >= root + bitv) begin
                val  = val - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // x / size in Q0.16, saturated just below one
    function automatic logic [63:0] coord_q16(input logic [COORD_BITS-1:0] c,
                                              input logic [SIZE_BITS-1:0] size);
        logic [63:0] div;
        logic [63:0] q;
        div = (size == 0) ? 64'd1 : 64'(size);
        q   = (64'(c) << 16) / div;
        return (q > 64'd65535) ? 64'd65535 : q;
    endfunction

    // base ^ exponent via the staged log2 / exp2 scheme, Q1.16 result
    function automatic logic [63:0] falloff_factor(input logic [63:0] base,
                                                   input logic [EXP_BITS-1:0] e);
        int          k;
        logic [63:0] mant;
        logic [63:0] frac;
        logic [63:0] n;
        logic [63:0] ipart;
        logic [63:0] fpart;
        logic [63:0] acc;
        longint      lg;
        longint      prod;
        longint      y;
        if (e == 0) return 64'd65536;
        if (base == 0) return 64'd0;
        k = 0;
        while (k < 62 && (base >> (k + 1)) != 0) k++;
        mant = (k > 16) ? (base >> (k - 16)) : (base << (16 - k));
        frac = '0;
        for (int r = 0; r < 16; r++) begin
            mant = (mant * mant) >> 16;
            frac = frac << 1;
            if (mant >= (64'd1 << 17)) begin
                frac = frac | 64'd1;
                mant = mant >> 1;
            end
        end
        lg   = longint'(k) * 65536 - 16 * 65536 + longint'(frac);
        prod = lg * longint'({48'd0, e});
        if (prod >= 0) return 64'd65536;
        // floor toward minus infinity
        y     = -((-prod + 4095) / 4096);
        n     = 64'(-y);
        ipart = n >> 16;
        fpart = n & 64'hFFFF;
        if (ipart > 16) return 64'd0;
        acc = 64'd1 << 32;
        for (int r = 1; r <= 16; r++) begin
            if (fpart[16 - r]) acc = (acc * exp2_root[r]) >> 32;
        end
        return (acc >> 16) >> ipart;
    endfunction

    function automatic t_shaded shade_pixel(input t_pixel px);
        logic [63:0] u;
        logic [63:0] v;
        logic [63:0] pu;
        logic [63:0] pv;
        logic [63:0] base;
        logic [63:0] fac;
        t_shaded     res;
        u    = coord_q16(px.x, frame_w);
        v    = coord_q16(px.y, frame_h);
        pu   = (u * (64'd65536 - u)) >> 16;
        pv   = (v * (64'd65536 - v)) >> 16;
        base = ((((pu * pv) >> 16)) * 64'(gain_q8)) >> 8;
        fac  = falloff_factor(base, exponent_q12);
        if (fac > 64'd65536) fac = 64'd65536;
        res.r = CHANNEL_BITS'((64'(px.r) * fac) >> 16);
        res.g = CHANNEL_BITS'((64'(px.g) * fac) >> 16);
        res.b = CHANNEL_BITS'((64'(px.b) * fac) >> 16);
        res.a = px.a;
        return res;
    endfunction

    // Drive one register write; called at a falling edge with the block idle.
    task automatic write_reg(input t_cfg_reg sel, input int val);
        i_cfg_we    = 1'b1;
        i_cfg_index = sel;
        i_cfg_data  = CFG_BITS'(val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (sel)
            REG_WIDTH:    frame_w      = SIZE_BITS'(val);
            REG_HEIGHT:   frame_h      = SIZE_BITS'(val);
            REG_GAIN:     gain_q8      = GAIN_BITS'(val);
            REG_EXPONENT: exponent_q12 = EXP_BITS'(val);
            default: ;
        endcase
        reg_writes++;
    endtask

    // Wait for every expected result, then let the pipeline settle.
    task automatic drain_results();
        while (shade_queue.size() != 0) @(negedge i_clk);
        repeat (PIPE_WAIT) @(negedge i_clk);
    endtask

    // Offer one pixel beat and hold it until accepted; enter and leave at a falling edge.
    task automatic send_pixel(input t_pixel px, input t_shaded want);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_pixel_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_pixel_valid = 1'b1;
        i_pixel_x     = px.x;
        i_pixel_y     = px.y;
        i_red_in      = px.r;
        i_green_in    = px.g;
        i_blue_in     = px.b;
        i_alpha_in    = px.a;
        @(posedge i_clk);
        while (!o_pixel_ready) @(posedge i_clk);
        shade_queue.push_back(want);
        pixels_sent++;
        @(negedge i_clk);
        i_pixel_valid = 1'b0;
    endtask

    function automatic int pick_size();
        case ($urandom_range(3))
            0:       return 1;
            1:       return 4096;
            2:       return $urandom_range(1, 4096);
            default: return $urandom_range(2, 64);
        endcase
    endfunction

    function automatic int pick_q(input int lo, input int hi);
        case ($urandom_range(3))
            0:       return 0;
            1:       return 65535;
            2:       return $urandom_range(0, 65535);
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    function automatic t_pixel random_pixel();
        t_pixel px;
        int     wlim;
        int     hlim;
        wlim = (frame_w == 0) ? 1 : ((frame_w > 4096) ? 4096 : int'(frame_w));
        hlim = (frame_h == 0) ? 1 : ((frame_h > 4096) ? 4096 : int'(frame_h));
        // mostly inside the frame, the rest anywhere in the coordinate range
        if ($urandom_range(99) < 80) begin
            px.x = COORD_BITS'($urandom_range(0, wlim - 1));
            px.y = COORD_BITS'($urandom_range(0, hlim - 1));
        end else begin
            px.x = COORD_BITS'($urandom);
            px.y = COORD_BITS'($urandom);
        end
        px.r = CHANNEL_BITS'($urandom);
        px.g = CHANNEL_BITS'($urandom);
        px.b = CHANNEL_BITS'($urandom);
        px.a = CHANNEL_BITS'($urandom);
        return px;
    endfunction

    t_vec_row vectors [] = '{
        // reset settings: corner pixel has zero base, so colour goes black
        '{0, REG_WIDTH, 0, '{12'd0, 12'd0, 8'd255, 8'd255, 8'd255, 8'd255},
          1, '{8'd0, 8'd0, 8'd0, 8'd255}},
        // centre of a 1024 x 768 frame
        '{0, REG_WIDTH, 0, '{12'd512, 12'd384, 8'd255, 8'd128, 8'd1, 8'd0}, 0, '{0, 0, 0, 0}},
        // coordinates beyond the frame saturate, base collapses to zero
        '{0, REG_WIDTH, 0, '{12'd4095, 12'd4095, 8'd200, 8'd100, 8'd50, 8'd170},
          1, '{8'd0, 8'd0, 8'd0, 8'd170}},
        '{0, REG_WIDTH, 0, '{12'd100, 12'd700, 8'd0, 8'd255, 8'd77, 8'd85}, 0, '{0, 0, 0, 0}},
        '{0, REG_WIDTH, 0, '{12'd1023, 12'd767, 8'd255, 8'd255, 8'd255, 8'd1},
          0, '{0, 0, 0, 0}},
        // full gain: base above one with positive exponent clamps to unity
        '{1, REG_GAIN, 65535, '{12'd512, 12'd384, 8'd255, 8'd170, 8'd85, 8'd34},
          1, '{8'd255, 8'd170, 8'd85, 8'd34}},
        '{0, REG_WIDTH, 0, '{12'd300, 12'd200, 8'd90, 8'd91, 8'd92, 8'd93}, 0, '{0, 0, 0, 0}},
        // zero exponent: factor is unity even when the base is zero
        '{1, REG_EXPONENT, 0, '{12'd0, 12'd0, 8'd200, 8'd17, 8'd255, 8'd99},
          1, '{8'd200, 8'd17, 8'd255, 8'd99}},
        '{0, REG_WIDTH, 0, '{12'd4095, 12'd10, 8'd1, 8'd2, 8'd3, 8'd4},
          1, '{8'd1, 8'd2, 8'd3, 8'd4}},
        // steepest falloff with the weakest gain
        '{1, REG_EXPONENT, 65535, '{12'd512, 12'd384, 8'd255, 8'd255, 8'd255, 8'd0},
          0, '{0, 0, 0, 0}},
        '{1, REG_GAIN, 1, '{12'd512, 12'd384, 8'd255, 8'd255, 8'd255, 8'd255},
          0, '{0, 0, 0, 0}},
        '{1, REG_GAIN, 0, '{12'd512, 12'd384, 8'd255, 8'd255, 8'd255, 8'd66},
          1, '{8'd0, 8'd0, 8'd0, 8'd66}},
        // towards a one-pixel frame: once it is set, coordinates saturate or sit at zero
        '{1, REG_GAIN, 3840, '{12'd0, 12'd0, 8'd10, 8'd20, 8'd30, 8'd40}, 0, '{0, 0, 0, 0}},
        '{1, REG_EXPONENT, 4096, '{12'd1, 12'd0, 8'd10, 8'd20, 8'd30, 8'd40},
          0, '{0, 0, 0, 0}},
        '{1, REG_WIDTH, 1, '{12'd0, 12'd1, 8'd10, 8'd20, 8'd30, 8'd40}, 0, '{0, 0, 0, 0}},
        '{1, REG_HEIGHT, 1, '{12'd1, 12'd1, 8'd10, 8'd20, 8'd30, 8'd40}, 0, '{0, 0, 0, 0}},
        // largest frame
        '{1, REG_WIDTH, 4096, '{12'd2048, 12'd0, 8'd255, 8'd255, 8'd255, 8'd255},
          0, '{0, 0, 0, 0}},
        '{1, REG_HEIGHT, 4096, '{12'd2048, 12'd2048, 8'd255, 8'd128, 8'd64, 8'd32},
          0, '{0, 0, 0, 0}},
        '{0, REG_WIDTH, 0, '{12'd4095, 12'd2048, 8'd255, 8'd255, 8'd255, 8'd255},
          0, '{0, 0, 0, 0}},
        '{0, REG_WIDTH, 0, '{12'd1, 12'd4094, 8'd255, 8'd255, 8'd255, 8'd255},
          0, '{0, 0, 0, 0}}
    };

    initial begin
        logic [63:0] c;
        t_pixel      px;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = REG_WIDTH;
        i_cfg_data     = '0;
        i_pixel_valid  = 1'b0;
        i_pixel_x      = '0;
        i_pixel_y      = '0;
        i_red_in       = '0;
        i_green_in     = '0;
        i_blue_in      = '0;
        i_alpha_in     = '0;
        i_result_ready = 1'b0;
        tx_idle_pct    = 20;
        rx_idle_pct    = 75;
        pixels_sent    = 0;
        reg_writes     = 0;

        // square-root chain for the exp2 constants
        c = 64'd1 << 31;
        for (int k = 1; k <= 16; k++) begin
            c = int_sqrt(c << 32);
            exp2_root[k] = c;
        end

        // hold reset, then load the register defaults into the local copy
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n      = 1'b1;
        frame_w      = 13'd1024;
        frame_h      = 13'd768;
        gain_q8      = 16'd3840;
        exponent_q12 = 16'd1024;

        // directed table
        foreach (vectors[i]) begin
            if (vectors[i].do_write) begin
                drain_results();
                write_reg(vectors[i].reg_sel, vectors[i].reg_val);
            end
            send_pixel(vectors[i].px,
                       vectors[i].typed ? vectors[i].shade : shade_pixel(vectors[i].px));
        end

        // random part: three idling phases, each split into blocks of fresh settings
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin tx_idle_pct = 20; rx_idle_pct = 75; end
                1:       begin tx_idle_pct = 75; rx_idle_pct = 20; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            for (int blk = 0; blk < 8; blk++) begin
                drain_results();
                write_reg(REG_WIDTH, pick_size());
                write_reg(REG_HEIGHT, pick_size());
                write_reg(REG_GAIN, pick_q(256, 8192));
                write_reg(REG_EXPONENT, pick_q(256, 8192));
                for (int n = 0; n < 52; n++) begin
                    px = random_pixel();
                    send_pixel(px, shade_pixel(px));
                end
            end
        end

        while (shade_queue.size() != 0) @(negedge i_clk);
        repeat (PIPE_WAIT) @(negedge i_clk);

        $display("covered %0d pixels, %0d results checked, %0d register writes, %0d mismatches",
                 pixels_sent, pixels_checked, reg_writes, mismatches);
        if (mismatches == 0 && shade_queue.size() == 0) begin
            $display("pixel_vignette_shader_tb: PASS");
        end else begin
            $display("pixel_vignette_shader_tb: FAIL");
        end
        $finish;
    end

endmodule
